// ===== sv/swing_step_sequencer_events_defines.svh =====
// assertion helpers used by the step sequencer
`ifndef SWING_STEP_SEQUENCER_EVENTS_DEFINES_SVH
`define SWING_STEP_SEQUENCER_EVENTS_DEFINES_SVH

// same-cycle implication
`define SSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sse_pkg.sv =====
package sse_pkg;

    localparam int VEL_W            = 7;
    localparam int NOTE_W           = 7;
    localparam int TIME_W           = 17;
    localparam int CFG_DATA_W       = 9;
    localparam int NOTE_OFF_DELAY   = 230;
    localparam int SWING_CENTER     = 128;
    localparam int SWING_FULL       = 256;
    localparam int BEATS_RESET      = 4;
    localparam int DIVS_RESET       = 4;
    localparam int SWING_RESET      = 128;
    localparam int LANES_USED_RESET = 0;

    typedef enum logic [1:0] {
        CMD_SET_HIT  = 2'd0,
        CMD_SET_NOTE = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_GENERATE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_BEATS         = 2'd0,
        REG_DIVS_PER_BEAT = 2'd1,
        REG_SWING         = 2'd2,
        REG_LANES_USED    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] lane;
        logic [7:0] division;
        logic [6:0] value;
    } request_t;

    typedef struct packed {
        logic        is_event;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [16:0] event_time;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [4:0] beats;
        logic [4:0] divs_per_beat;
        logic [8:0] swing;
        logic [4:0] lanes_used;
    } cfg_t;

    typedef struct packed {
        logic div_trim;
        logic lane_trim;
    } trim_t;

endpackage

// ===== sv/sse_cfg.sv =====
module sse_cfg
    import sse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  reg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output trim_t                 trim
);

    cfg_t  cfg_reg, cfg_next;
    trim_t trim_reg, trim_next;

    always_comb
    begin
        cfg_next  = cfg_reg;
        trim_next = '0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BEATS:
                begin
                    if (cfg_data[4:0] != '0)
                    begin
                        cfg_next.beats     = cfg_data[4:0];
                        trim_next.div_trim = 1'b1;
                    end
                end
                REG_DIVS_PER_BEAT:
                begin
                    if (cfg_data[4:0] != '0)
                    begin
                        cfg_next.divs_per_beat = cfg_data[4:0];
                        trim_next.div_trim     = 1'b1;
                    end
                end
                REG_SWING:
                begin
                    cfg_next.swing = cfg_data[8:0];
                end
                REG_LANES_USED:
                begin
                    cfg_next.lanes_used = cfg_data[4:0];
                    trim_next.lane_trim = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{beats:         5'(BEATS_RESET),
                         divs_per_beat: 5'(DIVS_RESET),
                         swing:         9'(SWING_RESET),
                         lanes_used:    5'(LANES_USED_RESET)};
            trim_reg <= '0;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            trim_reg <= trim_next;
        end
    end

    assign cfg  = cfg_reg;
    assign trim = trim_reg;

endmodule

// ===== sv/swing_step_sequencer_events.sv =====
// set note: writes the note table; set hit: read-modify-write of one grid row
// generate: the grid row is read and loaded, then scanned one lane per cycle,
//   pausing after each hit to emit its note-off; no new request is taken meanwhile
// clear, reset and time signature or lane count writes run a read-modify-write
//   pass over every row of the grid memory with busy held high
// results are strobed for one cycle from an output register, no back-pressure
`include "swing_step_sequencer_events_defines.svh"

module swing_step_sequencer_events
    import sse_pkg::*;
#(
    parameter int LANES         = 16,
    parameter int MAX_DIVISIONS = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  request_t              request,
    output logic                  busy,
    output logic                  result_valid,
    output result_t               result,
    input  logic                  cfg_we,
    input  reg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CNT_W  = $clog2(LANES + 1);
    localparam int ROW_W  = (MAX_DIVISIONS > 1) ? $clog2(MAX_DIVISIONS) : 1;
    localparam int TOT_W  = $clog2(MAX_DIVISIONS + 1);
    localparam int PROD_W = 10;
    localparam int CMP_W  = (TOT_W > PROD_W) ? TOT_W : PROD_W;
    localparam int LCMP_W = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIT_WR,
        ST_GEN_LOAD,
        ST_GEN_SCAN,
        ST_GEN_OFF
    } state_t;

    typedef logic [LANES-1:0][VEL_W-1:0] grid_row_t;

    cfg_t  cfg;
    trim_t trim;

    sse_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .trim      (trim)
    );

    state_t                         state_reg, state_next;
    logic                           result_valid_reg, result_valid_next;
    result_t                        result_reg, result_next;
    logic [TIME_W-1:0]              time_reg, time_next;
    logic [7:0]                     div_reg, div_next;
    logic [LANE_W-1:0]              hit_lane_reg, hit_lane_next;
    logic [VEL_W-1:0]               hit_val_reg, hit_val_next;
    logic [ROW_W-1:0]               hit_row_reg, hit_row_next;
    grid_row_t                      row_reg, row_next;
    logic [LANE_W-1:0]              scan_reg, scan_next;
    logic [LANES-1:0][NOTE_W-1:0]   notes_reg, notes_next;
    logic                           sw_active_reg, sw_active_next;
    logic [ROW_W-1:0]               sw_row_reg, sw_row_next;
    logic                           sw_wb_reg, sw_wb_next;
    logic [ROW_W-1:0]               sw_wb_row_reg, sw_wb_row_next;
    logic [TOT_W-1:0]               div_thr_reg, div_thr_next;
    logic [CNT_W-1:0]               lane_thr_reg, lane_thr_next;

    grid_row_t grid_mem [MAX_DIVISIONS];
    grid_row_t grid_rdata_reg;

    logic              mem_re;
    logic [ROW_W-1:0]  mem_raddr;
    logic              mem_we;
    logic [ROW_W-1:0]  mem_waddr;
    grid_row_t         mem_wdata;
    grid_row_t         sweep_wdata;
    grid_row_t         hit_wdata;
    grid_row_t         gen_row;

    logic [LCMP_W-1:0]      lane_ext;
    logic [LCMP_W-1:0]      lc_ext;
    logic [LCMP_W-1:0]      used_w;
    logic [PROD_W-1:0]      prod;
    logic [CMP_W-1:0]       prod_w;
    logic [CMP_W-1:0]       total_w;
    logic [CMP_W-1:0]       div_w;
    logic                   hit_ok;
    logic                   note_ok;
    logic                   div_ok;
    logic                   accept;
    logic                   sweeping;
    logic                   sweep_start;
    logic                   row_drop;
    logic [LANES-1:0]       used_mask;
    logic [LANES-1:0]       keep_mask;
    logic [TOT_W-1:0]       div_cand;
    logic [CNT_W-1:0]       lane_cand;
    logic [8:0]             swing_sat;
    logic signed [10:0]     swing_dev;
    logic signed [10:0]     swing_off;
    logic signed [TIME_W:0] base_s;
    logic signed [TIME_W:0] off_s;
    logic signed [TIME_W:0] gen_time_s;
    logic [TIME_W-1:0]      gen_time;

    // config-derived limits
    assign lane_ext = LCMP_W'(request.lane);
    assign lc_ext   = LCMP_W'(cfg.lanes_used);
    assign used_w   = (lc_ext > LCMP_W'(LANES)) ? LCMP_W'(LANES) : lc_ext;
    assign prod     = PROD_W'(cfg.beats) * PROD_W'(cfg.divs_per_beat);
    assign prod_w   = CMP_W'(prod);
    assign total_w  = (prod_w > CMP_W'(MAX_DIVISIONS)) ? CMP_W'(MAX_DIVISIONS) : prod_w;
    assign div_w    = CMP_W'(request.division);
    assign note_ok  = lane_ext < used_w;
    assign div_ok   = div_w < total_w;
    assign hit_ok   = note_ok && div_ok;

    assign sweeping = sw_active_reg || sw_wb_reg;
    assign busy     = (state_reg != ST_IDLE) || sweeping || trim.div_trim || trim.lane_trim;
    assign accept   = start && !busy;

    // swing shift
    assign swing_sat  = cfg.swing[8] ? 9'(SWING_FULL) : cfg.swing;
    assign swing_dev  = $signed({2'b00, swing_sat}) - $signed(11'(SWING_CENTER));
    assign swing_off  = swing_dev <<< 1;
    assign base_s     = $signed({2'b00, request.division, 8'h00});
    assign off_s      = $signed({{(TIME_W - 10){swing_off[10]}}, swing_off});

    always_comb
    begin
        case (request.division[1:0])
            2'd1:    gen_time_s = base_s + off_s;
            2'd3:    gen_time_s = base_s - off_s;
            default: gen_time_s = base_s;
        endcase
    end

    assign gen_time = gen_time_s[TIME_W-1:0];

    // lane masks and row data paths
    assign row_drop = CMP_W'(sw_wb_row_reg) >= CMP_W'(div_thr_reg);

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            used_mask[i]   = LCMP_W'(i) < used_w;
            keep_mask[i]   = LCMP_W'(i) < LCMP_W'(lane_thr_reg);
            sweep_wdata[i] = (keep_mask[i] && !row_drop) ? grid_rdata_reg[i] : '0;
            gen_row[i]     = used_mask[i] ? grid_rdata_reg[i] : '0;
        end
        hit_wdata               = grid_rdata_reg;
        hit_wdata[hit_lane_reg] = hit_val_reg;
    end

    assign mem_re    = sw_active_reg
                       || (accept && (((request.cmd == CMD_SET_HIT) && hit_ok)
                                      || ((request.cmd == CMD_GENERATE) && div_ok)));
    assign mem_raddr = sw_active_reg ? sw_row_reg : div_w[ROW_W-1:0];
    assign mem_we    = sw_wb_reg || (state_reg == ST_HIT_WR);
    assign mem_waddr = sw_wb_reg ? sw_wb_row_reg : hit_row_reg;
    assign mem_wdata = sw_wb_reg ? sweep_wdata : hit_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            grid_rdata_reg <= grid_mem[mem_raddr];
        end
    end

    // clearing pass thresholds
    always_comb
    begin
        sweep_start = trim.div_trim || trim.lane_trim || (accept && (request.cmd == CMD_CLEAR));
        div_cand    = TOT_W'(MAX_DIVISIONS);
        lane_cand   = CNT_W'(LANES);
        if (accept && (request.cmd == CMD_CLEAR))
        begin
            div_cand = '0;
        end
        else if (trim.div_trim)
        begin
            div_cand = total_w[TOT_W-1:0];
        end
        if (trim.lane_trim)
        begin
            lane_cand = used_w[CNT_W-1:0];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        time_next         = time_reg;
        div_next          = div_reg;
        hit_lane_next     = hit_lane_reg;
        hit_val_next      = hit_val_reg;
        hit_row_next      = hit_row_reg;
        row_next          = row_reg;
        scan_next         = scan_reg;
        notes_next        = notes_reg;
        sw_active_next    = sw_active_reg;
        sw_row_next       = sw_row_reg;
        sw_wb_next        = sw_active_reg;
        sw_wb_row_next    = sw_row_reg;
        div_thr_next      = div_thr_reg;
        lane_thr_next     = lane_thr_reg;

        if (sweep_start)
        begin
            sw_active_next = 1'b1;
            sw_row_next    = '0;
            div_thr_next   = (sweeping && (div_thr_reg < div_cand)) ? div_thr_reg : div_cand;
            lane_thr_next  = (sweeping && (lane_thr_reg < lane_cand)) ? lane_thr_reg : lane_cand;
        end
        else if (sw_active_reg)
        begin
            sw_row_next = sw_row_reg + ROW_W'(1);
            if (sw_row_reg == ROW_W'(MAX_DIVISIONS - 1))
            begin
                sw_active_next = 1'b0;
            end
        end

        if (trim.lane_trim)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (!used_mask[i])
                begin
                    notes_next[i] = '0;
                end
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.cmd)
                        CMD_SET_HIT:
                        begin
                            if (hit_ok)
                            begin
                                hit_lane_next = lane_ext[LANE_W-1:0];
                                hit_val_next  = request.value;
                                hit_row_next  = div_w[ROW_W-1:0];
                                state_next    = ST_HIT_WR;
                            end
                        end
                        CMD_SET_NOTE:
                        begin
                            if (note_ok)
                            begin
                                notes_next[lane_ext[LANE_W-1:0]] = request.value;
                            end
                        end
                        CMD_GENERATE:
                        begin
                            if (div_ok)
                            begin
                                time_next  = gen_time;
                                div_next   = request.division;
                                state_next = ST_GEN_LOAD;
                            end
                            else
                            begin
                                result_valid_next = 1'b1;
                                result_next       = '{is_event:   1'b0,
                                                      note:       '0,
                                                      velocity:   '0,
                                                      event_time: {1'b0, request.division, 8'h00},
                                                      last:       1'b1};
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_HIT_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_GEN_LOAD:
            begin
                if (gen_row == '0)
                begin
                    result_valid_next = 1'b1;
                    result_next       = '{is_event:   1'b0,
                                          note:       '0,
                                          velocity:   '0,
                                          event_time: {1'b0, div_reg, 8'h00},
                                          last:       1'b1};
                    state_next        = ST_IDLE;
                end
                else
                begin
                    row_next   = gen_row;
                    scan_next  = '0;
                    state_next = ST_GEN_SCAN;
                end
            end
            ST_GEN_SCAN:
            begin
                if (row_reg[scan_reg] != '0)
                begin
                    result_valid_next  = 1'b1;
                    result_next        = '{is_event:   1'b1,
                                           note:       notes_reg[scan_reg],
                                           velocity:   row_reg[scan_reg],
                                           event_time: time_reg,
                                           last:       1'b0};
                    row_next[scan_reg] = '0;
                    state_next         = ST_GEN_OFF;
                end
                else
                begin
                    scan_next = scan_reg + LANE_W'(1);
                end
            end
            ST_GEN_OFF:
            begin
                result_valid_next = 1'b1;
                result_next       = '{is_event:   1'b1,
                                      note:       result_reg.note,
                                      velocity:   '0,
                                      event_time: time_reg + TIME_W'(NOTE_OFF_DELAY),
                                      last:       (row_reg == '0)};
                if (row_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next  = scan_reg + LANE_W'(1);
                    state_next = ST_GEN_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            time_reg         <= '0;
            div_reg          <= '0;
            hit_lane_reg     <= '0;
            hit_val_reg      <= '0;
            hit_row_reg      <= '0;
            row_reg          <= '0;
            scan_reg         <= '0;
            notes_reg        <= '0;
            sw_active_reg    <= 1'b1;
            sw_row_reg       <= '0;
            sw_wb_reg        <= 1'b0;
            sw_wb_row_reg    <= '0;
            div_thr_reg      <= '0;
            lane_thr_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
            time_reg         <= time_next;
            div_reg          <= div_next;
            hit_lane_reg     <= hit_lane_next;
            hit_val_reg      <= hit_val_next;
            hit_row_reg      <= hit_row_next;
            row_reg          <= row_next;
            scan_reg         <= scan_next;
            notes_reg        <= notes_next;
            sw_active_reg    <= sw_active_next;
            sw_row_reg       <= sw_row_next;
            sw_wb_reg        <= sw_wb_next;
            sw_wb_row_reg    <= sw_wb_row_next;
            div_thr_reg      <= div_thr_next;
            lane_thr_reg     <= lane_thr_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `SSE_ASSERT_IMP(a_last_idle, result_valid && result.last, state_reg == ST_IDLE, "last item left the sequencer active")
    `SSE_ASSERT_NEXT(a_off_follows_on, result_valid && result.is_event && (result.velocity != '0), result_valid && result.is_event && (result.velocity == '0), "note-on without note-off")
    `SSE_ASSERT_IMP(a_marker_last, result_valid && !result.is_event, result.last, "empty marker not last")
    `SSE_ASSERT_IMP(a_hit_wr_no_sweep, state_reg == ST_HIT_WR, !sw_wb_reg && !sw_active_reg, "hit write during clearing pass")
    `SSE_ASSERT_NEXT(a_trim_sweeps, trim.div_trim || trim.lane_trim, sw_active_reg && (sw_row_reg == '0), "trim did not restart clearing pass")

endmodule
